// ===== src/alil_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alil_pkg: shared types and codes of the array list unit
// Command codes, status codes, field widths and the result record.
// ----------------------------------------------------------------------------
package alil_pkg;

    localparam int CMD_W = 2;
    localparam int POS_W = 8;
    localparam int VAL_W = 32;
    localparam int STS_W = 2;
    localparam int LEN_W = 8;

    localparam logic [CMD_W-1:0] CMD_INSERT  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DEL_MIN = 2'd2;

    localparam logic [STS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STS_W-1:0] ST_BAD  = 2'd1;
    localparam logic [STS_W-1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [STS_W-1:0]        status;
        logic signed [VAL_W-1:0] removed_value;
        logic [LEN_W-1:0]        length_after;
    } t_result;

endpackage

// ===== src/alil_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alil_if: item channels of the array list unit
// Command channel and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface alil_in_if import alil_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [CMD_W-1:0]        command;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] new_value;

    modport source (output valid, command, position, new_value, input ready);
    modport sink   (input valid, command, position, new_value, output ready);
endinterface

interface alil_out_if import alil_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [STS_W-1:0]        status;
    logic signed [VAL_W-1:0] removed_value;
    logic [LEN_W-1:0]        length_after;

    modport source (output valid, status, removed_value, length_after, input ready);
    modport sink   (input valid, status, removed_value, length_after, output ready);
endinterface

// ===== src/alil_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alil_ram: list storage
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module alil_ram import alil_pkg::*; #(
    parameter int CAPACITY = 128
) (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [$clog2(CAPACITY)-1:0]  i_waddr,
    input  logic [VAL_W-1:0]             i_wdata,
    input  logic                         i_re,
    input  logic [$clog2(CAPACITY)-1:0]  i_raddr,
    output logic [VAL_W-1:0]             o_rdata
);

    logic [VAL_W-1:0] r_mem [CAPACITY];
    logic [VAL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/alil_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alil_seq: command sequencer
// Checks each command, then shifts or scans the storage one entry a cycle.
// ----------------------------------------------------------------------------
module alil_seq import alil_pkg::*; #(
    parameter int CAPACITY = 128
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [CMD_W-1:0]             i_command,
    input  logic [POS_W-1:0]             i_position,
    input  logic [VAL_W-1:0]             i_new_value,
    output logic                         o_res_valid,
    input  logic                         i_res_ack,
    output t_result                      o_res,
    output logic                         o_we,
    output logic [$clog2(CAPACITY)-1:0]  o_waddr,
    output logic [VAL_W-1:0]             o_wdata,
    output logic                         o_re,
    output logic [$clog2(CAPACITY)-1:0]  o_raddr,
    input  logic [VAL_W-1:0]             i_rdata
);

    localparam int AW = $clog2(CAPACITY);
    localparam int LW = $clog2(CAPACITY + 1);
    localparam int CW = ((LW > POS_W) ? LW : POS_W) + 1;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_UP   = 5'b00010,
        S_DEL  = 5'b00100,
        S_SCAN = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state           r_state, n_state;
    logic [LW-1:0]    r_len, n_len;
    logic [LW-1:0]    r_k, n_k;
    logic [AW-1:0]    r_idx, n_idx;
    logic             r_pend, n_pend;
    logic [AW-1:0]    r_paddr, n_paddr;
    logic [VAL_W-1:0] r_val, n_val;
    logic [VAL_W-1:0] r_best_val, n_best_val;
    logic [AW-1:0]    r_best_idx, n_best_idx;
    logic             r_have_best, n_have_best;
    logic [STS_W-1:0] r_status, n_status;
    logic [VAL_W-1:0] r_removed, n_removed;

    logic [CW-1:0] pos_x;
    logic [CW-1:0] len_x;
    logic [CW-1:0] pos_m1;
    logic [LW-1:0] k_m1;
    logic [LW-1:0] idx_l;

    assign pos_x  = CW'(i_position);
    assign len_x  = CW'(r_len);
    assign pos_m1 = pos_x - CW'(1);
    assign k_m1   = r_k - LW'(1);
    assign idx_l  = LW'(r_idx);

    always_comb begin
        n_state     = r_state;
        n_len       = r_len;
        n_k         = r_k;
        n_idx       = r_idx;
        n_pend      = r_pend;
        n_paddr     = r_paddr;
        n_val       = r_val;
        n_best_val  = r_best_val;
        n_best_idx  = r_best_idx;
        n_have_best = r_have_best;
        n_status    = r_status;
        n_removed   = r_removed;
        o_ready     = 1'b0;
        o_res_valid = 1'b0;
        o_we        = 1'b0;
        o_waddr     = r_paddr;
        o_wdata     = i_rdata;
        o_re        = 1'b0;
        o_raddr     = r_k[AW-1:0];

        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_status  = ST_BAD;
                    n_removed = '0;
                    n_pend    = 1'b0;
                    n_idx     = pos_m1[AW-1:0];
                    n_state   = S_DONE;
                    unique case (i_command)
                        CMD_INSERT: begin
                            if (pos_x >= CW'(1) && pos_x <= len_x + CW'(1)) begin
                                if (r_len == LW'(CAPACITY)) begin
                                    n_status = ST_FULL;
                                end else begin
                                    n_k     = r_len;
                                    n_val   = i_new_value;
                                    n_state = S_UP;
                                end
                            end
                        end
                        CMD_DELETE: begin
                            if (pos_x >= CW'(1) && pos_x <= len_x) begin
                                n_k     = pos_m1[LW-1:0];
                                n_state = S_DEL;
                            end
                        end
                        CMD_DEL_MIN: begin
                            if (r_len != '0) begin
                                n_k         = '0;
                                n_have_best = 1'b0;
                                n_state     = S_SCAN;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_UP: begin
                if (r_pend) begin
                    o_we    = 1'b1;
                    o_waddr = r_paddr + AW'(1);
                end
                if (r_k > idx_l) begin
                    o_re    = 1'b1;
                    o_raddr = k_m1[AW-1:0];
                    n_pend  = 1'b1;
                    n_paddr = k_m1[AW-1:0];
                    n_k     = k_m1;
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        o_we     = 1'b1;
                        o_waddr  = r_idx;
                        o_wdata  = r_val;
                        n_len    = r_len + LW'(1);
                        n_status = ST_OK;
                        n_state  = S_DONE;
                    end
                end
            end
            S_DEL: begin
                if (r_pend) begin
                    if (r_paddr == r_idx) begin
                        n_removed = i_rdata;
                    end else begin
                        o_we    = 1'b1;
                        o_waddr = r_paddr - AW'(1);
                    end
                end
                if (r_k < r_len) begin
                    o_re    = 1'b1;
                    n_pend  = 1'b1;
                    n_paddr = r_k[AW-1:0];
                    n_k     = r_k + LW'(1);
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        n_len    = r_len - LW'(1);
                        n_status = ST_OK;
                        n_state  = S_DONE;
                    end
                end
            end
            S_SCAN: begin
                if (r_pend) begin
                    if (!r_have_best || $signed(i_rdata) < $signed(r_best_val)) begin
                        n_best_val  = i_rdata;
                        n_best_idx  = r_paddr;
                        n_have_best = 1'b1;
                    end
                end
                if (r_k < r_len) begin
                    o_re    = 1'b1;
                    n_pend  = 1'b1;
                    n_paddr = r_k[AW-1:0];
                    n_k     = r_k + LW'(1);
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        n_idx   = r_best_idx;
                        n_k     = LW'(r_best_idx);
                        n_state = S_DEL;
                    end
                end
            end
            S_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_ack) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_len   <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k         <= n_k;
        r_idx       <= n_idx;
        r_paddr     <= n_paddr;
        r_val       <= n_val;
        r_best_val  <= n_best_val;
        r_best_idx  <= n_best_idx;
        r_have_best <= n_have_best;
        r_status    <= n_status;
        r_removed   <= n_removed;
    end

    assign o_res.status        = r_status;
    assign o_res.removed_value = r_removed;
    assign o_res.length_after  = LEN_W'(r_len);

endmodule

// ===== src/array_list_insert_delete_min_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// array_list_insert_delete_min_unit: fixed-capacity ordered list
// Insert at position, delete at position, delete minimum; one result per item.
// Steps: a rejected item goes straight to its result; insert at p shifts
//   the entries from p up, delete at p shifts those after p down, delete
//   minimum scans the list, then deletes at the minimum; one entry per cycle
//   through the one read port and one write port of the list storage.
// Throughput: one item at a time; the next is taken once the result moves
//   to the output register.
// Reset: synchronous, active low; the list is empty, storage is not cleared.
// ----------------------------------------------------------------------------
module array_list_insert_delete_min_unit import alil_pkg::*; #(
    parameter int CAPACITY = 128
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    alil_in_if.sink   i_in,
    alil_out_if.source o_out
);

    localparam int AW = $clog2(CAPACITY);

    logic             res_valid;
    logic             res_ack;
    t_result          res;
    logic             we;
    logic [AW-1:0]    waddr;
    logic [VAL_W-1:0] wdata;
    logic             re;
    logic [AW-1:0]    raddr;
    logic [VAL_W-1:0] rdata;

    logic    r_out_valid;
    t_result r_out;

    alil_seq #(.CAPACITY(CAPACITY)) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in.valid),
        .o_ready     (i_in.ready),
        .i_command   (i_in.command),
        .i_position  (i_in.position),
        .i_new_value (i_in.new_value),
        .o_res_valid (res_valid),
        .i_res_ack   (res_ack),
        .o_res       (res),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_wdata     (wdata),
        .o_re        (re),
        .o_raddr     (raddr),
        .i_rdata     (rdata)
    );

    alil_ram #(.CAPACITY(CAPACITY)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign res_ack = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_ack) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ack) begin
            r_out <= res;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.status        = r_out.status;
    assign o_out.removed_value = r_out.removed_value;
    assign o_out.length_after  = r_out.length_after;

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for array_list_insert_delete_min_unit
// Drives insert, delete and delete-minimum commands over the valid/ready
// command channel and checks every result against a queue-based copy of the
// list. The random phase fills the list to capacity and drains it again.
// Both channels idle at random, and the result side holds off for long
// stretches so that the unit backs up into its command input.
// ----------------------------------------------------------------------------
module tb;
    import alil_pkg::*;

    localparam int LIST_CAP     = 128;
    localparam int RANDOM_ITEMS = 1600;
    localparam int HOLD_CYCLES  = 600;
    localparam int DRAIN_CYCLES = 300;
    localparam int LIMIT_CYCLES = 2_000_000;

    localparam logic [CMD_W-1:0]        CMD_UNUSED = 2'd3;
    localparam logic signed [VAL_W-1:0] VAL_MIN    = 32'sh8000_0000;
    localparam logic signed [VAL_W-1:0] VAL_MAX    = 32'sh7fff_ffff;

    class array_list_shadow;
        logic signed [VAL_W-1:0] entries[$];
        t_result                 pending_results[$];
        int                      mismatches;
        int                      checked;
        int                      full_rejects;

        function int length();
            return entries.size();
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        function void note_command(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] pos,
                                   logic signed [VAL_W-1:0] val);
            t_result r;
            int      n;
            int      p;
            int      best;
            n               = entries.size();
            p               = pos;
            r.status        = ST_BAD;
            r.removed_value = '0;
            case (cmd)
                CMD_INSERT: begin
                    if (p >= 1 && p <= n + 1) begin
                        if (n >= LIST_CAP) begin
                            r.status = ST_FULL;
                            full_rejects++;
                        end else begin
                            entries.insert(p - 1, val);
                            r.status = ST_OK;
                        end
                    end
                end
                CMD_DELETE: begin
                    if (p >= 1 && p <= n) begin
                        r.removed_value = entries[p - 1];
                        entries.delete(p - 1);
                        r.status = ST_OK;
                    end
                end
                CMD_DEL_MIN: begin
                    if (n > 0) begin
                        best = 0;
                        for (int k = 1; k < n; k++) begin
                            if (entries[k] < entries[best]) best = k;
                        end
                        r.removed_value = entries[best];
                        entries.delete(best);
                        r.status = ST_OK;
                    end
                end
                default: ;
            endcase
            r.length_after = LEN_W'(entries.size());
            pending_results.push_back(r);
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (pending_results.size() == 0) begin
                $error("result with nothing outstanding: status %0d removed %0d length %0d",
                       got.status, got.removed_value, got.length_after);
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            checked++;
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                mismatches++;
            end
            if (got.removed_value !== want.removed_value) begin
                $error("removed_value: expected %0d, got %0d",
                       want.removed_value, got.removed_value);
                mismatches++;
            end
            if (got.length_after !== want.length_after) begin
                $error("length_after: expected %0d, got %0d",
                       want.length_after, got.length_after);
                mismatches++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    alil_in_if  cmd_ch ();
    alil_out_if res_ch ();

    array_list_insert_delete_min_unit #(
        .CAPACITY(LIST_CAP)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (cmd_ch),
        .o_out  (res_ch)
    );

    array_list_shadow shadow = new();

    int cycles;
    int items_sent;
    int results_seen;
    int fills;
    bit cmd_quiet;
    bit res_quiet;

    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYCLES) begin
            $display("tb: timeout after %0d cycles", cycles);
            $display("tb: done, errors");
            $finish;
        end
    end

    function automatic logic signed [VAL_W-1:0] draw_value();
        case ($urandom_range(0, 9))
            0:       return VAL_MIN;
            1:       return VAL_MAX;
            2, 3, 4: return $signed($urandom_range(0, 6)) - 3;
            default: return $urandom();
        endcase
    endfunction

    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                             input logic signed [VAL_W-1:0] val);
        int gap;
        gap = cmd_quiet ? 0 : $urandom_range(0, 4);
        if ($urandom_range(0, 39) == 0) cmd_quiet = !cmd_quiet;
        if (gap > 0) begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_ch.valid     <= 1'b1;
        cmd_ch.command   <= cmd;
        cmd_ch.position  <= pos;
        cmd_ch.new_value <= val;
        do @(posedge i_clk); while (!cmd_ch.ready);
        shadow.note_command(cmd, pos, val);
        items_sent++;
    endtask

    task automatic take_results();
        int      gap;
        t_result got;
        forever begin
            if (results_seen == 250 || results_seen == 1000) gap = HOLD_CYCLES;
            else gap = res_quiet ? 0 : $urandom_range(0, 4);
            if ($urandom_range(0, 39) == 0) res_quiet = !res_quiet;
            if (gap > 0) begin
                res_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!res_ch.valid);
            got.status        = res_ch.status;
            got.removed_value = res_ch.removed_value;
            got.length_after  = res_ch.length_after;
            shadow.check_result(got);
            results_seen++;
        end
    endtask

    task automatic pick_command(input bit filling, input int n,
                                output logic [CMD_W-1:0] cmd,
                                output logic [POS_W-1:0] pos,
                                output logic signed [VAL_W-1:0] val);
        int r;
        int ins_share;
        r         = $urandom_range(0, 99);
        ins_share = filling ? 70 : 12;
        val       = draw_value();
        pos       = POS_W'($urandom());
        if (r < ins_share) begin
            cmd = CMD_INSERT;
            case ($urandom_range(0, 3))
                0:       pos = POS_W'(1);
                1:       pos = POS_W'(n + 1);
                default: pos = POS_W'($urandom_range(1, n + 1));
            endcase
        end else if (r < 82) begin
            cmd = (n > 0 && $urandom_range(0, 1)) ? CMD_DELETE : CMD_DEL_MIN;
            if (cmd == CMD_DELETE) pos = POS_W'($urandom_range(1, n));
        end else if (r < 90) begin
            cmd = CMD_INSERT;
            pos = $urandom_range(0, 3) == 0 ? '0 : POS_W'($urandom_range(n + 2, 255));
        end else if (r < 97) begin
            cmd = CMD_DELETE;
            pos = $urandom_range(0, 3) == 0 ? '0 : POS_W'($urandom_range(n + 1, 255));
        end else begin
            cmd = CMD_UNUSED;
        end
    endtask

    initial begin
        logic [CMD_W-1:0]        cmd;
        logic [POS_W-1:0]        pos;
        logic signed [VAL_W-1:0] val;
        bit                      filling;
        int                      n;

        i_rst_n          <= 1'b0;
        cmd_ch.valid     <= 1'b0;
        cmd_ch.command   <= CMD_INSERT;
        cmd_ch.position  <= '0;
        cmd_ch.new_value <= '0;
        res_ch.ready     <= 1'b0;
        cycles           <= 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        fork
            take_results();
        join_none

        // empty list, bad positions, unused code
        send_item(CMD_DEL_MIN, 0, 0);
        send_item(CMD_DELETE, 1, 0);
        send_item(CMD_DELETE, 0, 0);
        send_item(CMD_INSERT, 0, 7);
        send_item(CMD_INSERT, 2, 7);
        send_item(CMD_UNUSED, 255, -1);
        // build MIN, 5, 5, MAX
        send_item(CMD_INSERT, 1, 5);
        send_item(CMD_INSERT, 2, VAL_MAX);
        send_item(CMD_INSERT, 1, VAL_MIN);
        send_item(CMD_INSERT, 2, 5);
        send_item(CMD_INSERT, 255, 9);
        send_item(CMD_DELETE, 5, 0);
        send_item(CMD_DELETE, 255, 0);
        send_item(CMD_DEL_MIN, 0, 0);
        send_item(CMD_DEL_MIN, 0, 0);
        send_item(CMD_DELETE, 2, 0);
        send_item(CMD_INSERT, 1, -1);
        send_item(CMD_DELETE, 1, 0);
        send_item(CMD_DEL_MIN, 0, 0);
        send_item(CMD_DEL_MIN, 0, 0);
        send_item(CMD_INSERT, 1, 32'sh5555_5555);
        send_item(CMD_INSERT, 1, 32'shaaaa_aaaa);
        send_item(CMD_INSERT, 3, 0);

        filling = 1'b1;
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            n = shadow.length();
            if (n == LIST_CAP && filling && $urandom_range(0, 7) == 0) begin
                filling = 1'b0;
                fills++;
            end
            if (n == 0) filling = 1'b1;
            if ($urandom_range(0, 299) == 0) filling = !filling;
            pick_command(filling, n, cmd, pos, val);
            send_item(cmd, pos, val);
        end
        cmd_ch.valid <= 1'b0;

        while (shadow.pending() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("tb: %0d commands sent, %0d results checked", items_sent, shadow.checked);
        $display("tb: list filled to capacity %0d times, %0d inserts refused as full",
                 fills, shadow.full_rejects);
        if (shadow.mismatches == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
